/* rtl/pidtc_pkg.sv */
// ============================================================================
// pidtc_pkg
// Shared widths, codes and command/status types of the clamped PID block.
// ============================================================================
`default_nettype none

package pidtc_pkg;

    // Data format
    localparam int DATA_W  = 32;              // Q16.16 operands
    localparam int FRAC_W  = 16;              // fraction bits
    localparam int ERR_W   = DATA_W + 1;      // error register width
    localparam int DIFF_W  = DATA_W + 2;      // error sum / difference width
    localparam int MAG_W   = DATA_W + 1;      // magnitude of error difference
    localparam int DIVD_W  = MAG_W + FRAC_W;  // dividend and quotient width
    localparam int DERIV_W = DIVD_W + 1;      // signed derivative width
    localparam int ACC_W   = 64;              // integral and PID sum width

    // Sequential multiplier: 64-bit A by 34-bit B, 16 bits of A per pass
    localparam int MUL_A_W   = ACC_W;
    localparam int MUL_B_W   = DIFF_W;
    localparam int DIGIT_W   = 16;
    localparam int MUL_STEPS = MUL_A_W / DIGIT_W;
    localparam int PP_W      = DIGIT_W + 1 + MUL_B_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // Serial divider: one quotient bit per cycle
    localparam int DIV_CNT_W = $clog2(DIVD_W);

    // Stream payload widths
    localparam int S_TDATA_W = 3 * DATA_W;
    localparam int M_TDATA_W = ((DATA_W + 2 + 7) / 8) * 8;

    // Configuration registers
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd5;
    localparam logic [DATA_W-1:0]    PERIOD_RESET   = 32'd655;

    // Clamp status codes
    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_MAX  = 2'd1;
    localparam logic [1:0] CLAMP_MIN  = 2'd2;
    localparam logic [1:0] CLAMP_BAD  = 2'd3;

    // Item kind carried on tuser
    localparam logic FUNC_COMPUTE = 1'b0;
    localparam logic FUNC_CLEAR   = 1'b1;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MUL_ISTEP = 2'd0,   // (prev + cur error) * step
        MUL_PROP  = 2'd1,   // prop_gain * error
        MUL_IGAIN = 2'd2,   // integ_gain * integral
        MUL_DGAIN = 2'd3    // deriv_gain * derivative
    } mul_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     clear_state;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     integ_add;
        logic     pid_load;
        logic     pid_add;
        logic     out_pid;
        logic     out_zero;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/pidtc_mul.sv */
// ============================================================================
// pidtc_mul
// Sequential signed multiplier: 64-bit A by 34-bit B, one 16-bit digit of A
// per cycle, followed by a floor shift of 16 or 17 and saturation to 64 bits.
// ============================================================================
`default_nettype none

module pidtc_mul (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic        [pidtc_pkg::MUL_A_W-1:0] a_in,
    input  wire logic signed [pidtc_pkg::MUL_B_W-1:0] b_in,
    input  wire logic                                 shr_extra,
    output logic                                      done,
    output logic             [pidtc_pkg::ACC_W-1:0]   result
);

    logic        [pidtc_pkg::MUL_A_W-1:0]   a_reg;
    logic signed [pidtc_pkg::MUL_B_W-1:0]   b_reg;
    logic        [pidtc_pkg::PROD_W-1:0]    acc_reg;
    logic        [pidtc_pkg::PROD_W-1:0]    acc_next;
    logic        [pidtc_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                                   busy_reg;
    logic                                   done_reg;
    logic                                   shr_reg;

    logic signed [pidtc_pkg::DIGIT_W:0]     digit;
    logic signed [pidtc_pkg::PP_W-1:0]      pp;
    logic signed [pidtc_pkg::PROD_W-1:0]    shifted;
    logic        [pidtc_pkg::PROD_W-pidtc_pkg::ACC_W:0] upper;
    logic                                   fits;

    // Top digit is signed, lower digits are unsigned
    assign digit = {(cnt_reg == '0) ? a_reg[pidtc_pkg::MUL_A_W-1] : 1'b0,
                    a_reg[pidtc_pkg::MUL_A_W-1 -: pidtc_pkg::DIGIT_W]};
    assign pp    = digit * b_reg;

    // Horner accumulation, most significant digit first
    assign acc_next = (acc_reg << pidtc_pkg::DIGIT_W)
                    + {{(pidtc_pkg::PROD_W - pidtc_pkg::PP_W){pp[pidtc_pkg::PP_W-1]}}, pp};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == pidtc_pkg::MUL_CNT_W'(pidtc_pkg::MUL_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operand and accumulator payload
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            shr_reg <= shr_extra;
            acc_reg <= '0;
        end else if (busy_reg) begin
            a_reg   <= a_reg << pidtc_pkg::DIGIT_W;
            acc_reg <= acc_next;
        end
    end

    // Floor shift and saturate to signed 64 bits
    assign shifted = shr_reg ? ($signed(acc_reg) >>> (pidtc_pkg::FRAC_W + 1))
                             : ($signed(acc_reg) >>> pidtc_pkg::FRAC_W);
    assign upper   = shifted[pidtc_pkg::PROD_W-1:pidtc_pkg::ACC_W-1];
    assign fits    = (&upper) | (~|upper);

    always_comb begin
        if (fits) begin
            result = shifted[pidtc_pkg::ACC_W-1:0];
        end else if (acc_reg[pidtc_pkg::PROD_W-1]) begin
            result = {1'b1, {(pidtc_pkg::ACC_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(pidtc_pkg::ACC_W-1){1'b1}}};
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/pidtc_div.sv */
// ============================================================================
// pidtc_div
// Restoring serial divider: (magnitude << FRAC_W) / step, one quotient bit
// per cycle, truncated.
// ============================================================================
`default_nettype none

module pidtc_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [pidtc_pkg::MAG_W-1:0]       mag_in,
    input  wire logic [pidtc_pkg::DATA_W-1:0]      den_in,
    output logic                                   done,
    output logic      [pidtc_pkg::DIVD_W-1:0]      quotient
);

    logic [pidtc_pkg::DIVD_W-1:0]    sh_reg;     // dividend out, quotient in
    logic [pidtc_pkg::DIVD_W-1:0]    sh_next;
    logic [pidtc_pkg::DATA_W-1:0]    rem_reg;
    logic [pidtc_pkg::DATA_W-1:0]    rem_next;
    logic [pidtc_pkg::DATA_W-1:0]    den_reg;
    logic [pidtc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [pidtc_pkg::DATA_W:0]      trial;
    logic [pidtc_pkg::DATA_W:0]      trial_sub;
    logic                            take;

    // One restoring step
    assign trial     = {rem_reg, sh_reg[pidtc_pkg::DIVD_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign take      = (trial >= {1'b0, den_reg});
    assign rem_next  = take ? trial_sub[pidtc_pkg::DATA_W-1:0]
                            : trial[pidtc_pkg::DATA_W-1:0];
    assign sh_next   = {sh_reg[pidtc_pkg::DIVD_W-2:0], take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == pidtc_pkg::DIV_CNT_W'(pidtc_pkg::DIVD_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= {mag_in, {pidtc_pkg::FRAC_W{1'b0}}};
            rem_reg <= '0;
            den_reg <= den_in;
        end else if (busy_reg) begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

`default_nettype wire

/* rtl/pidtc_datapath.sv */
// ============================================================================
// pidtc_datapath
// Configuration registers, error and integral state, multiplier and divider
// units, PID accumulator, output clamp and output register.
// ============================================================================
`default_nettype none

module pidtc_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [pidtc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [pidtc_pkg::DATA_W-1:0]          cfg_wr_data,
    input  wire logic [pidtc_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire pidtc_pkg::cmd_t                       cmd,
    output pidtc_pkg::status_t                         status,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [pidtc_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int DW = pidtc_pkg::DATA_W;
    localparam int AW = pidtc_pkg::ACC_W;

    // Configuration registers
    logic signed [DW-1:0] prop_gain_reg;
    logic signed [DW-1:0] integ_gain_reg;
    logic signed [DW-1:0] deriv_gain_reg;
    logic signed [DW-1:0] out_min_reg;
    logic signed [DW-1:0] out_max_reg;
    logic        [DW-1:0] period_reg;
    logic                 gain_wr;

    // Controller state
    logic signed [AW-1:0]                     integ_reg;
    logic signed [AW-1:0]                     integ_next;
    logic signed [pidtc_pkg::ERR_W-1:0]       cur_err_reg;
    logic signed [pidtc_pkg::ERR_W-1:0]       prev_err_reg;
    logic        [DW-1:0]                     dt_reg;
    logic signed [AW-1:0]                     pid_reg;
    logic signed [AW-1:0]                     pid_next;

    // Output register
    logic                 m_tvalid_reg;
    logic signed [DW-1:0] control_reg;
    logic        [1:0]    clamp_reg;

    // Input fields
    logic signed [DW-1:0]              setpoint;
    logic signed [DW-1:0]              measured;
    logic        [DW-1:0]              step_time;
    logic signed [pidtc_pkg::ERR_W-1:0] err_in;

    // Arithmetic helpers
    logic signed [pidtc_pkg::DIFF_W-1:0]  err_sum;
    logic signed [pidtc_pkg::DIFF_W-1:0]  err_diff;
    logic        [pidtc_pkg::DIFF_W-1:0]  diff_abs;
    logic        [pidtc_pkg::DIVD_W-1:0]  quotient;
    logic signed [pidtc_pkg::DERIV_W-1:0] deriv;
    logic        [pidtc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pidtc_pkg::MUL_B_W-1:0] mul_b;
    logic                                 mul_shr;
    logic        [AW-1:0]                 mul_res;
    logic                                 mul_done;
    logic                                 div_done;

    // Clamp
    logic signed [AW-1:0] max_ext;
    logic signed [AW-1:0] min_ext;
    logic signed [AW-1:0] after_max;
    logic                 over_max;
    logic                 under_min;
    logic signed [DW-1:0] clamped;
    logic        [1:0]    clamp_code;

    // Saturating 64-bit add
    function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] x,
                                              input logic [AW-1:0] y);
        logic [AW:0] s;
        s = {x[AW-1], x} + {y[AW-1], y};
        if (s[AW] != s[AW-1]) begin
            sat_add = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            sat_add = s[AW-1:0];
        end
    endfunction

    // Unpack the input transaction
    assign setpoint  = s_tdata[DW-1:0];
    assign measured  = s_tdata[2*DW-1:DW];
    assign step_time = s_tdata[3*DW-1:2*DW];
    assign err_in    = {setpoint[DW-1], setpoint} - {measured[DW-1], measured};

    // Configuration writes; a gain write also clears the state
    assign gain_wr = cfg_wr_en && ((cfg_addr == pidtc_pkg::REG_PROP_GAIN)  ||
                                   (cfg_addr == pidtc_pkg::REG_INTEG_GAIN) ||
                                   (cfg_addr == pidtc_pkg::REG_DERIV_GAIN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            out_min_reg    <= {1'b1, {(DW-1){1'b0}}};
            out_max_reg    <= {1'b0, {(DW-1){1'b1}}};
            period_reg     <= pidtc_pkg::PERIOD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pidtc_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_wr_data;
                pidtc_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_wr_data;
                pidtc_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_wr_data;
                pidtc_pkg::REG_OUT_MIN:    out_min_reg    <= cfg_wr_data;
                pidtc_pkg::REG_OUT_MAX:    out_max_reg    <= cfg_wr_data;
                pidtc_pkg::REG_PERIOD:     period_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Error terms from the captured errors
    assign err_sum  = {prev_err_reg[pidtc_pkg::ERR_W-1], prev_err_reg}
                    + {cur_err_reg[pidtc_pkg::ERR_W-1], cur_err_reg};
    assign err_diff = {cur_err_reg[pidtc_pkg::ERR_W-1], cur_err_reg}
                    - {prev_err_reg[pidtc_pkg::ERR_W-1], prev_err_reg};
    assign diff_abs = err_diff[pidtc_pkg::DIFF_W-1] ? (-err_diff) : err_diff;

    // Derivative is zero when the step is zero
    always_comb begin
        if (dt_reg == '0) begin
            deriv = '0;
        end else if (err_diff[pidtc_pkg::DIFF_W-1]) begin
            deriv = -$signed({1'b0, quotient});
        end else begin
            deriv = $signed({1'b0, quotient});
        end
    end

    // Select multiplier operands
    always_comb begin
        case (cmd.mul_sel)
            pidtc_pkg::MUL_ISTEP: begin
                mul_a   = {{(pidtc_pkg::MUL_A_W-DW){1'b0}}, dt_reg};
                mul_b   = err_sum;
                mul_shr = 1'b1;
            end
            pidtc_pkg::MUL_PROP: begin
                mul_a   = {{(pidtc_pkg::MUL_A_W-pidtc_pkg::ERR_W){cur_err_reg[pidtc_pkg::ERR_W-1]}},
                           cur_err_reg};
                mul_b   = {{(pidtc_pkg::MUL_B_W-DW){prop_gain_reg[DW-1]}}, prop_gain_reg};
                mul_shr = 1'b0;
            end
            pidtc_pkg::MUL_IGAIN: begin
                mul_a   = integ_reg;
                mul_b   = {{(pidtc_pkg::MUL_B_W-DW){integ_gain_reg[DW-1]}}, integ_gain_reg};
                mul_shr = 1'b0;
            end
            default: begin
                mul_a   = {{(pidtc_pkg::MUL_A_W-pidtc_pkg::DERIV_W){deriv[pidtc_pkg::DERIV_W-1]}},
                           deriv};
                mul_b   = {{(pidtc_pkg::MUL_B_W-DW){deriv_gain_reg[DW-1]}}, deriv_gain_reg};
                mul_shr = 1'b0;
            end
        endcase
    end

    pidtc_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mul_start),
        .a_in      (mul_a),
        .b_in      (mul_b),
        .shr_extra (mul_shr),
        .done      (mul_done),
        .result    (mul_res)
    );

    pidtc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .mag_in   (diff_abs[pidtc_pkg::MAG_W-1:0]),
        .den_in   (dt_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Integral and error history
    assign integ_next = sat_add(integ_reg, mul_res);

    always_ff @(posedge aclk) begin
        if (!aresetn || gain_wr || cmd.clear_state) begin
            integ_reg    <= '0;
            cur_err_reg  <= '0;
            prev_err_reg <= '0;
        end else if (cmd.capture) begin
            prev_err_reg <= cur_err_reg;
            cur_err_reg  <= err_in;
        end else if (cmd.integ_add) begin
            integ_reg <= integ_next;
        end
    end

    // Step time and PID sum
    assign pid_next = cmd.pid_load ? $signed(mul_res) : sat_add(pid_reg, mul_res);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dt_reg <= (step_time == '0) ? period_reg : step_time;
        end
        if (cmd.pid_load || cmd.pid_add) begin
            pid_reg <= pid_next;
        end
    end

    // Clamp: max test first, then min test on the result
    assign max_ext   = {{(AW-DW){out_max_reg[DW-1]}}, out_max_reg};
    assign min_ext   = {{(AW-DW){out_min_reg[DW-1]}}, out_min_reg};
    assign over_max  = (pid_reg > max_ext);
    assign after_max = over_max ? max_ext : pid_reg;
    assign under_min = (after_max < min_ext);

    always_comb begin
        if (under_min) begin
            clamped    = out_min_reg;
            clamp_code = pidtc_pkg::CLAMP_MIN;
        end else if (over_max) begin
            clamped    = out_max_reg;
            clamp_code = pidtc_pkg::CLAMP_MAX;
        end else begin
            clamped    = pid_reg[DW-1:0];
            clamp_code = pidtc_pkg::CLAMP_NONE;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_pid || cmd.out_zero) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_pid) begin
            control_reg <= clamped;
            clamp_reg   <= clamp_code;
        end else if (cmd.out_zero) begin
            control_reg <= '0;
            clamp_reg   <= pidtc_pkg::CLAMP_NONE;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(pidtc_pkg::M_TDATA_W-DW-2){1'b0}}, clamp_reg, control_reg};

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

/* rtl/pidtc_ctrl.sv */
// ============================================================================
// pidtc_ctrl
// Sequencer of one PID step: integral update, three gain products and the
// derivative division, then the output load; a clear loads a zero output.
// ============================================================================
`default_nettype none

module pidtc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tuser,
    output logic                    s_tready,
    output pidtc_pkg::cmd_t         cmd,
    input  wire pidtc_pkg::status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_ISTEP_W,
        ST_PROP,
        ST_PROP_W,
        ST_IGAIN,
        ST_IGAIN_W,
        ST_DIV_W,
        ST_DGAIN,
        ST_DGAIN_W,
        ST_OUT,
        ST_CLR_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Commands and next state
    always_comb begin
        cmd         = '0;
        cmd.mul_sel = pidtc_pkg::MUL_ISTEP;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == pidtc_pkg::FUNC_CLEAR) begin
                        cmd.clear_state = 1'b1;
                        state_next      = ST_CLR_OUT;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidtc_pkg::MUL_ISTEP;
                cmd.div_start = 1'b1;
                state_next    = ST_ISTEP_W;
            end
            ST_ISTEP_W: begin
                if (status.mul_done) begin
                    cmd.integ_add = 1'b1;
                    state_next    = ST_PROP;
                end
            end
            ST_PROP: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidtc_pkg::MUL_PROP;
                state_next    = ST_PROP_W;
            end
            ST_PROP_W: begin
                if (status.mul_done) begin
                    cmd.pid_load = 1'b1;
                    state_next   = ST_IGAIN;
                end
            end
            ST_IGAIN: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidtc_pkg::MUL_IGAIN;
                state_next    = ST_IGAIN_W;
            end
            ST_IGAIN_W: begin
                if (status.mul_done) begin
                    cmd.pid_add = 1'b1;
                    state_next  = ST_DIV_W;
                end
            end
            ST_DIV_W: begin
                if (status.div_done) begin
                    state_next = ST_DGAIN;
                end
            end
            ST_DGAIN: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = pidtc_pkg::MUL_DGAIN;
                state_next    = ST_DGAIN_W;
            end
            ST_DGAIN_W: begin
                if (status.mul_done) begin
                    cmd.pid_add = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_pid = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_CLR_OUT: begin
                if (status.out_free) begin
                    cmd.out_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pid_trapezoid_clamped.sv */
// ============================================================================
// pid_trapezoid_clamped
// PID controller, Q16.16, trapezoidal integral, clamped output.
// ============================================================================
// Input stream (s_*): one transaction per control step. s_tuser selects the
// kind: 0 computes a step, 1 clears the integral and the error history and
// returns control 0 with status 0. A step time of 0 uses the period register.
// Output stream (m_*): one transaction per input transaction, in order,
// carrying the clamped drive value and the clamp status.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_addr;
// writes of the three gains also clear the integral and errors.
// Flow: a compute step reaches m_tvalid after the serial divider for the
// derivative, followed by one four-pass multiply (16 bits of the 64-bit
// operand per pass). The integral and gain products run alongside the
// division. A clear goes to a clear-output state that loads a zero result
// once the output register is free. s_tready is high only between items,
// so one item is in work at a time, and the next waits until it is done.
// When m_tready is low the finished result waits in the output register;
// the block still accepts and works on the next item and holds its result
// until the register frees. Reset restores the register defaults, clears
// the state and drops m_tvalid.
// ============================================================================
`default_nettype none

module pid_trapezoid_clamped (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [pidtc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [pidtc_pkg::DATA_W-1:0]        cfg_wr_data,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [pidtc_pkg::S_TDATA_W-1:0]     s_tdata,  // setpoint, measured, step_time
    input  wire logic                                s_tuser,  // func
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [pidtc_pkg::M_TDATA_W-1:0]     m_tdata   // control, clamp_status, zero pad
);

    pidtc_pkg::cmd_t    cmd;
    pidtc_pkg::status_t status;

    pidtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    pidtc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/pidtc_checker.sv */
// ============================================================================
// pidtc_checker
// Port-level checks of the clamped PID block, bound to the top level.
// ============================================================================
`default_nettype none

module pidtc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [pidtc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int DW = pidtc_pkg::DATA_W;

    // Reset drops the result channel
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One item in work at a time: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while item in work");

    // Clamp status is a legal code and padding is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DW+1:DW] != pidtc_pkg::CLAMP_BAD) &&
                     (m_tdata[pidtc_pkg::M_TDATA_W-1:DW+2] == '0))
        else $error("bad clamp status or padding");

    // A clear accepted while the result channel is free returns an all-zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && (!m_tvalid || m_tready)
            |=> ##1 m_tvalid && (m_tdata == '0))
        else $error("clear did not return zero");

endmodule

bind pid_trapezoid_clamped pidtc_checker u_pidtc_checker (.*);

`default_nettype wire

/* verif/pid_trapezoid_clamped_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// pid_trapezoid_clamped_tb
// Self-checking bench for the clamped trapezoidal PID controller.
// A queue-fed driver sends control steps and clears on the input stream with
// random gaps. A clocked monitor runs a bit-exact Q16.16 PID model on every
// accepted transaction. It checks each result transaction against the oldest
// predicted output. Register settings change between phases, only while
// the block is idle.
// ============================================================================

module pid_trapezoid_clamped_tb;
    import pidtc_pkg::*;

    localparam int STALL_LIMIT = 4000;   // cycles without any transaction
    localparam int SETTLE_CYC  = 70;     // a little over the compute latency
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 115;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;   // unmapped indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic              func;
        logic [DATA_W-1:0] setpoint;
        logic [DATA_W-1:0] measured;
        logic [DATA_W-1:0] step_time;
    } pid_step_t;

    typedef struct {
        logic [DATA_W-1:0] control;
        logic [1:0]        status;
    } pid_out_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr    = '0;
    logic [DATA_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    pid_trapezoid_clamped dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // setpoint, measured, step_time
        .s_tuser     (s_tuser),     // func
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)      // control, clamp_status, zero pad
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus and expectation stores
    pid_step_t steps_pending[$];
    pid_out_t  outputs_due[$];
    int        steps_queued   = 0;
    int        steps_accepted = 0;
    int        error_cnt      = 0;
    bit        no_idle        = 1'b0;
    bit        in_taken       = 1'b0;
    int        in_gap         = 0;
    int        out_gap        = 0;
    int        quiet_cyc      = 0;
    pid_step_t drv_step;

    // Controller model: registers and loop state
    longint gain_p, gain_i, gain_d, lim_lo, lim_hi, step_default;
    longint integ_acc, err_now, err_last;

    // (a * b) >> sh, floor rounding, saturated to signed 64 bits
    function automatic longint mul_fix(longint a, longint b, int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p  = (pa * pb) >>> sh;
        if (p[127:63] == '0 || p[127:63] == '1)
            return p[63:0];
        return p[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    // (diff << FRAC_W) / dt, truncated toward zero; dt is nonzero
    function automatic longint div_rate(longint diff, longint dt);
        longint unsigned m, q;
        m = (diff < 0) ? -diff : diff;
        q = (m << FRAC_W) / dt;
        return (diff < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void clear_loop();
        integ_acc = 0;
        err_now   = 0;
        err_last  = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        case (idx)
            REG_PROP_GAIN: begin
                gain_p = longint'($signed(val));
                clear_loop();
            end
            REG_INTEG_GAIN: begin
                gain_i = longint'($signed(val));
                clear_loop();
            end
            REG_DERIV_GAIN: begin
                gain_d = longint'($signed(val));
                clear_loop();
            end
            REG_OUT_MIN: lim_lo = longint'($signed(val));
            REG_OUT_MAX: lim_hi = longint'($signed(val));
            REG_PERIOD:  step_default = {32'd0, val};
            default: ;
        endcase
    endfunction

    // Advance the controller model by one step and form its output
    function automatic pid_out_t pid_predict(pid_step_t st);
        pid_out_t r;
        longint   dt, deriv, pid;
        r.control = '0;
        r.status  = CLAMP_NONE;
        if (st.func == FUNC_CLEAR) begin
            clear_loop();
            return r;
        end
        dt = (st.step_time == '0) ? step_default : {32'd0, st.step_time};
        err_last = err_now;
        err_now  = longint'($signed(st.setpoint)) - longint'($signed(st.measured));
        integ_acc = add_sat(integ_acc, mul_fix(err_last + err_now, dt, FRAC_W + 1));
        deriv = (dt == 0) ? 0 : div_rate(err_now - err_last, dt);
        pid = mul_fix(gain_p, err_now, FRAC_W);
        pid = add_sat(pid, mul_fix(gain_i, integ_acc, FRAC_W));
        pid = add_sat(pid, mul_fix(gain_d, deriv, FRAC_W));
        // max test first, so crossed limits end on out_min
        if (pid > lim_hi) begin
            pid      = lim_hi;
            r.status = CLAMP_MAX;
        end
        if (pid < lim_lo) begin
            pid      = lim_lo;
            r.status = CLAMP_MIN;
        end
        r.control = pid[DATA_W-1:0];
        return r;
    endfunction

    // Random helpers
    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 15);
        if (r == 0)
            return $urandom_range(30, 150);
        if (r < 8)
            return 0;
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [DATA_W-1:0] rnd_q16();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4:    return $urandom;
            default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rnd_step();
        case ($urandom_range(0, 7))
            0, 1:    return 32'h0;
            2:       return 32'h1;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom;
            default: return $urandom_range(1, 32'h2_0000);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rnd_gain();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return $urandom;
            default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
        endcase
    endfunction

    // Stimulus tasks, run from the sequence only
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_regs(logic [DATA_W-1:0] kp, logic [DATA_W-1:0] ki,
                            logic [DATA_W-1:0] kd, logic [DATA_W-1:0] lo,
                            logic [DATA_W-1:0] hi, logic [DATA_W-1:0] period);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
        write_reg(REG_PERIOD, period);
    endtask

    task automatic add_step(logic func, logic [DATA_W-1:0] sp, logic [DATA_W-1:0] meas,
                            logic [DATA_W-1:0] dt);
        pid_step_t st;
        st.func      = func;
        st.setpoint  = sp;
        st.measured  = meas;
        st.step_time = dt;
        steps_pending.push_back(st);
        steps_queued++;
    endtask

    // Hold until every step is accepted and answered, then let the block settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (steps_accepted != steps_queued || outputs_due.size() != 0);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    // Input driver: hold a transaction until accepted, then gap or advance
    always @(negedge aclk) begin
        if (!s_tvalid || in_taken) begin
            if (in_gap > 0 || steps_pending.size() == 0) begin
                if (in_gap > 0)
                    in_gap--;
                s_tvalid <= 1'b0;
            end else begin
                drv_step = steps_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_step.func;
                s_tdata  <= {drv_step.step_time, drv_step.measured, drv_step.setpoint};
                in_gap   = idle_gap();
            end
        end
    end

    // Result backpressure
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            out_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                out_gap = idle_gap();
        end
    end

    // Monitor: track register writes, predict accepted steps, check results
    always @(posedge aclk) begin
        pid_out_t exp_out;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (outputs_due.size() == 0) begin
                    $display("%0t: result with nothing pending, control %h status %0d",
                             $time, m_tdata[DATA_W-1:0], m_tdata[DATA_W+1:DATA_W]);
                    error_cnt++;
                end else begin
                    exp_out = outputs_due.pop_front();
                    if (m_tdata[DATA_W-1:0] !== exp_out.control) begin
                        $display("%0t: control mismatch, expected %h actual %h",
                                 $time, exp_out.control, m_tdata[DATA_W-1:0]);
                        error_cnt++;
                    end
                    if (m_tdata[DATA_W+1:DATA_W] !== exp_out.status) begin
                        $display("%0t: clamp status mismatch, expected %0d actual %0d",
                                 $time, exp_out.status, m_tdata[DATA_W+1:DATA_W]);
                        error_cnt++;
                    end
                end
            end
            if (cfg_wr_en)
                apply_reg(cfg_addr, cfg_wr_data);
            if (s_tvalid && s_tready) begin
                drv_step.func      = s_tuser;
                drv_step.setpoint  = s_tdata[DATA_W-1:0];
                drv_step.measured  = s_tdata[2*DATA_W-1:DATA_W];
                drv_step.step_time = s_tdata[3*DATA_W-1:2*DATA_W];
                outputs_due.push_back(pid_predict(drv_step));
                steps_accepted++;
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cyc);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Test sequence
    initial begin
        logic [DATA_W-1:0] sp, lo, hi, t;
        gain_p       = 0;
        gain_i       = 0;
        gain_d       = 0;
        lim_lo       = longint'($signed(32'h8000_0000));
        lim_hi       = longint'($signed(32'h7FFF_FFFF));
        step_default = {32'd0, PERIOD_RESET};
        clear_loop();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Moderate gains, full-range limits: extreme errors and steps
        set_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_0100,
                 32'h8000_0000, 32'h7FFF_FFFF, PERIOD_RESET);
        add_step(FUNC_COMPUTE, 32'h0001_0000, 32'h0, 32'h0);
        add_step(FUNC_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        add_step(FUNC_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
        add_step(FUNC_COMPUTE, 32'h0, 32'h0, 32'hFFFF_FFFF);
        add_step(FUNC_COMPUTE, 32'h1234_5678, 32'h1234_5678, 32'h0001_0000);
        add_step(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_step(FUNC_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_step(FUNC_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_step(FUNC_COMPUTE, 32'hFFFF_FFFF, 32'h0, 32'h2);
        add_step(FUNC_CLEAR, 32'h0, 32'h0, 32'h0);
        wait_idle();

        // Extreme gains, crossed limits, zero default step; unmapped writes ignored
        set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0005_0000, 32'hFFFB_0000, 32'h0);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_1234);
        add_step(FUNC_COMPUTE, 32'h0003_0000, 32'h0, 32'h0);
        add_step(FUNC_COMPUTE, 32'h0, 32'h0003_0000, 32'h0);
        add_step(FUNC_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_step(FUNC_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_step(FUNC_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
        add_step(FUNC_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
        wait_idle();

        // Narrow limits, largest default step: within, above and below
        set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF);
        add_step(FUNC_COMPUTE, 32'h0, 32'h0, 32'h0);
        add_step(FUNC_COMPUTE, 32'h0, 32'h0000_0001, 32'h0);
        add_step(FUNC_COMPUTE, 32'h0010_0000, 32'h0, 32'h0);
        add_step(FUNC_COMPUTE, 32'h0, 32'h0010_0000, 32'h0);
        add_step(FUNC_CLEAR, 32'h0, 32'h0, 32'h0);
        add_step(FUNC_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        wait_idle();

        // Random phases: new settings each time, some without idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            no_idle = (ph % 3 == 1);
            case ($urandom_range(0, 3))
                0: begin
                    lo = 32'h8000_0000;
                    hi = 32'h7FFF_FFFF;
                end
                1: begin
                    lo = $urandom;
                    hi = $urandom;
                    if ($signed(lo) > $signed(hi)) begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                end
                2: begin
                    hi = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
                    lo = hi + $urandom_range(1, 32'h4_0000);
                end
                default: begin
                    hi = $urandom_range(0, 32'h8_0000);
                    lo = -hi;
                end
            endcase
            case ($urandom_range(0, 4))
                0:       t = 32'h0;
                1:       t = 32'h1;
                2:       t = 32'hFFFF_FFFF;
                3:       t = PERIOD_RESET;
                default: t = $urandom_range(1, 32'h2_0000);
            endcase
            set_regs(rnd_gain(), rnd_gain(), rnd_gain(), lo, hi, t);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sp = rnd_q16();
                if ($urandom_range(0, 19) == 0)
                    add_step(FUNC_CLEAR, $urandom, $urandom, $urandom);
                else if ($urandom_range(0, 1) == 0)
                    // tracking loop: measurement near the setpoint
                    add_step(FUNC_COMPUTE, sp, sp + $urandom_range(0, 32'h2_0000) - 32'h1_0000,
                             rnd_step());
                else
                    add_step(FUNC_COMPUTE, sp, rnd_q16(), rnd_step());
            end
            wait_idle();
        end

        repeat (SETTLE_CYC) @(negedge aclk);
        if (outputs_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, outputs_due.size());
            error_cnt++;
        end
        if (error_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
